[design/etbrd_pkg.sv]
package etbrd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int TIME_W     = 32;
  localparam int THR_W      = 31;
  localparam int TAPS_W     = 7;
  localparam int RATE_W     = 16;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int SQ_W       = 31;   // square of a 16-bit sample is at most 2^30
  localparam int SPAN_W     = 12;   // spans that reach the rate test are <= 3000 ms
  localparam int Q8_W       = 18;
  localparam int NUM_W      = TAPS_W + Q8_W;
  localparam int PRD_W      = RATE_W + SPAN_W;

  localparam logic [TIME_W-1:0] STALE_SPAN_MS = 32'd3000;
  localparam logic [Q8_W-1:0]   MS_PER_S_Q8   = 18'd256000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_BURST_TAPS = 2'd1,
    REG_RATE_MIN   = 2'd2,
    REG_RATE_MAX   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [THR_W-1:0]  energy_threshold;
    logic [TAPS_W-1:0] burst_taps;
    logic [RATE_W-1:0] rate_min;
    logic [RATE_W-1:0] rate_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    energy_threshold: '0,
    burst_taps:       7'd4,
    rate_min:         16'd0,
    rate_max:         16'hFFFF
  };

  // one closed window handed from the energy stage to the tap stage
  typedef struct packed {
    logic              above;
    logic [TIME_W-1:0] time_ms;
  } win_t;

  function automatic logic [TAPS_W-1:0] eff_taps(input logic [TAPS_W-1:0] m);
    return (m == '0) ? TAPS_W'(1) : m;
  endfunction

endpackage

[design/energy_tap_burst_rate_detector.sv]
// A closing beat's result passes the squarer, energy compare and tap/rate result registers.
// Throughput: one sample per cycle, unless output back-pressure holds a window end;
// beats without window_end give no result.
// The ring read for the burst span is prefetched, so back-to-back window ends run at full rate.
// Reset: synchronous, active low; clears counters, pointers, valids and config to defaults.
// Ring contents are not cleared; the tap count gates every read, so no clearing pass is run.
module energy_tap_burst_rate_detector
  import etbrd_pkg::*;
#(
  parameter int RING_DEPTH = 64,
  parameter int MAX_WINDOW = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_window_end,
  input  logic [TIME_W-1:0]          in_time_ms,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_match,
  output logic                       out_tap,
  output logic                       out_above,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic win_valid;
  logic win_ready;
  win_t win;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD:  cfg_nxt.energy_threshold = cfg_wdata[THR_W-1:0];
        REG_BURST_TAPS: cfg_nxt.burst_taps       = cfg_wdata[TAPS_W-1:0];
        REG_RATE_MIN:   cfg_nxt.rate_min         = cfg_wdata[RATE_W-1:0];
        REG_RATE_MAX:   cfg_nxt.rate_max         = cfg_wdata[RATE_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  etbrd_energy #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_energy (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .in_window_end   (in_window_end),
    .in_time_ms      (in_time_ms),
    .energy_threshold(cfg_r.energy_threshold),
    .win_valid       (win_valid),
    .win_ready       (win_ready),
    .win             (win)
  );

  etbrd_burst #(
    .RING_DEPTH(RING_DEPTH)
  ) u_burst (
    .clk           (clk),
    .rst_n         (rst_n),
    .win_valid     (win_valid),
    .win_ready     (win_ready),
    .win           (win),
    .cfg           (cfg_r),
    .burst_taps_nxt(cfg_nxt.burst_taps),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_match     (out_match),
    .out_tap       (out_tap),
    .out_above     (out_above)
  );

endmodule

[design/etbrd_energy.sv]
module etbrd_energy
  import etbrd_pkg::*;
#(
  parameter int MAX_WINDOW = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_window_end,
  input  logic [TIME_W-1:0]          in_time_ms,
  input  logic [THR_W-1:0]           energy_threshold,
  output logic                       win_valid,
  input  logic                       win_ready,
  output win_t                       win
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SQ_W + $clog2(MAX_WINDOW);
  localparam int PROD_W = THR_W + CNT_W;

  logic              v1_r;
  logic [SQ_W-1:0]   sq1_r;
  logic              end1_r;
  logic [TIME_W-1:0] time1_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              v2_r;
  win_t              win_r;

  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic                         counted;
  logic [SUM_W-1:0]             sum_add;
  logic [CNT_W-1:0]             cnt_add;
  logic [PROD_W-1:0]            prod;
  logic                         above;
  logic                         ready2;
  logic                         go1;

  assign sq_full = in_sample * in_sample;

  assign ready2   = !v2_r || win_ready;
  assign go1      = v1_r && (!end1_r || ready2);
  assign in_ready = !v1_r || go1;

  // samples past the window limit are dropped, the closing one included
  assign counted = cnt_r < CNT_W'(MAX_WINDOW);
  assign sum_add = counted ? sum_r + SUM_W'(sq1_r) : sum_r;
  assign cnt_add = counted ? cnt_r + CNT_W'(1) : cnt_r;
  assign prod    = PROD_W'(energy_threshold) * PROD_W'(cnt_add);
  assign above   = PROD_W'(sum_add) > prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      if (in_ready) begin
        v1_r <= in_valid;
      end
      if (go1) begin
        if (end1_r) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_add;
          cnt_r <= cnt_add;
        end
      end
      if (go1 && end1_r) begin
        v2_r <= 1'b1;
      end else if (win_ready) begin
        v2_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sq1_r   <= sq_full[SQ_W-1:0];
      end1_r  <= in_window_end;
      time1_r <= in_time_ms;
    end
    if (go1 && end1_r) begin
      win_r.above   <= above;
      win_r.time_ms <= time1_r;
    end
  end

  assign win_valid = v2_r;
  assign win       = win_r;

endmodule

[design/etbrd_burst.sv]
module etbrd_burst
  import etbrd_pkg::*;
#(
  parameter int RING_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              win_valid,
  output logic              win_ready,
  input  win_t              win,
  input  cfg_t              cfg,
  input  logic [TAPS_W-1:0] burst_taps_nxt,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_match,
  output logic              out_tap,
  output logic              out_above
);

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int TOT_W = $clog2(RING_DEPTH + 1);
  localparam int XW    = (PTR_W + 2 > 8) ? PTR_W + 2 : 8;
  localparam int CW    = (TOT_W > TAPS_W) ? TOT_W : TAPS_W;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // slot that lies e entries behind p, with e clamped to the ring depth
  function automatic logic [PTR_W-1:0] ring_back(input logic [PTR_W-1:0] p,
                                                 input logic [TAPS_W-1:0] e);
    logic [XW-1:0] ea;
    logic [XW-1:0] s;
    ea = (XW'(e) > XW'(RING_DEPTH)) ? XW'(RING_DEPTH) : XW'(e);
    s  = XW'(p) + XW'(RING_DEPTH) - ea;
    if (s >= XW'(RING_DEPTH)) begin
      s = s - XW'(RING_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  logic [TIME_W-1:0] ring_mem [RING_DEPTH];

  logic [PTR_W-1:0]  wp_r;
  logic [TOT_W-1:0]  tot_r;
  logic              prev_r;
  logic [TIME_W-1:0] last_r;
  logic [TIME_W-1:0] rd_a_r;
  logic [TIME_W-1:0] rd_b_r;
  logic              out_valid_r;
  logic              match_r;
  logic              tap_r;
  logic              above_r;

  logic              go;
  logic              tap_hit;
  logic [TAPS_W-1:0] e;
  logic [TAPS_W-1:0] e_pf;
  logic [PTR_W-1:0]  wp_new;
  logic [PTR_W-1:0]  wp_nxt;
  logic [TOT_W-1:0]  tot_new;
  logic              enough;
  logic [TIME_W-1:0] old_t;
  logic [TIME_W-1:0] new_t;
  logic [TIME_W-1:0] span;
  logic              span_zero;
  logic              stale;
  logic [NUM_W-1:0]  num;
  logic [PRD_W-1:0]  lo_prod;
  logic [PRD_W-1:0]  hi_prod;
  logic              match;
  logic              we;
  logic [PTR_W-1:0]  addr_a;
  logic [PTR_W-1:0]  addr_b;

  assign win_ready = !out_valid_r || out_ready;
  assign go        = win_valid && win_ready;

  assign tap_hit = win.above && !prev_r;
  assign e       = eff_taps(cfg.burst_taps);
  assign wp_new  = tap_hit ? ptr_inc(wp_r) : wp_r;
  assign tot_new = (tap_hit && tot_r < TOT_W'(RING_DEPTH)) ? tot_r + TOT_W'(1) : tot_r;
  assign enough  = CW'(tot_new) >= CW'(e);

  // the prefetched slot already sits at the right distance from the new pointer
  assign old_t = tap_hit ? rd_b_r : rd_a_r;
  assign new_t = tap_hit ? win.time_ms : last_r;
  assign span  = new_t - old_t;

  // a single-tap burst compares the newest tap with itself
  assign span_zero = (span == '0) || (e == TAPS_W'(1));
  assign stale     = enough && !span_zero && (span > STALE_SPAN_MS);

  assign num     = NUM_W'(e - TAPS_W'(1)) * NUM_W'(MS_PER_S_Q8);
  assign lo_prod = PRD_W'(cfg.rate_min) * PRD_W'(span[SPAN_W-1:0]);
  assign hi_prod = PRD_W'(cfg.rate_max) * PRD_W'(span[SPAN_W-1:0]);
  assign match   = enough && !span_zero && !stale &&
                   (PRD_W'(num) >= lo_prod) && (PRD_W'(num) <= hi_prod);

  assign we     = go && tap_hit;
  assign wp_nxt = go ? (stale ? '0 : wp_new) : wp_r;
  assign e_pf   = eff_taps(burst_taps_nxt);
  assign addr_a = ring_back(wp_nxt, e_pf);
  assign addr_b = ring_back(ptr_inc(wp_nxt), e_pf);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      tot_r       <= '0;
      prev_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (win_ready) begin
        out_valid_r <= win_valid;
      end
      if (go) begin
        wp_r   <= wp_nxt;
        tot_r  <= stale ? '0 : tot_new;
        prev_r <= stale ? 1'b0 : win.above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      match_r <= match;
      tap_r   <= tap_hit;
      above_r <= win.above;
    end
    if (we) begin
      last_r <= win.time_ms;
    end
  end

  // ring: one write port, two prefetch reads with write-through
  always_ff @(posedge clk) begin
    if (we) begin
      ring_mem[wp_r] <= win.time_ms;
    end
    rd_a_r <= (we && addr_a == wp_r) ? win.time_ms : ring_mem[addr_a];
    rd_b_r <= (we && addr_b == wp_r) ? win.time_ms : ring_mem[addr_b];
  end

  assign out_valid = out_valid_r;
  assign out_match = match_r;
  assign out_tap   = tap_r;
  assign out_above = above_r;

  a_stale_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go && stale |=> tot_r == '0 && wp_r == '0 && !prev_r)
    else $error("stale burst did not clear tap state");

  a_tap_records: assert property (@(posedge clk) disable iff (!rst_n)
    go && tap_hit |=> last_r == $past(win.time_ms))
    else $error("newest tap time not recorded");

  a_pointer_holds: assert property (@(posedge clk) disable iff (!rst_n)
    go && !tap_hit && !stale |=> wp_r == $past(wp_r) && tot_r == $past(tot_r))
    else $error("ring pointer moved without a tap");

  a_tap_above: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tap |-> out_above)
    else $error("tap reported on a window below threshold");

endmodule
